// ===== sv/mst_pkg.sv =====
package mst_pkg;

    localparam int TRIG_TABLE_BITS = 10;
    localparam int TAB_N = 1 << TRIG_TABLE_BITS;
    localparam int FS_SIN = 30 - TRIG_TABLE_BITS;
    localparam int FS_ASIN = 28 - TRIG_TABLE_BITS;
    localparam int MAC_SHIFT = 24;

    typedef logic signed [65:0] t_acc;
    typedef logic signed [32:0] t_opnd;
    typedef logic signed [29:0] t_tab_word;
    typedef t_tab_word t_tab [0:TAB_N];
    typedef logic [3:0] t_cfg_idx;
    typedef logic [TRIG_TABLE_BITS:0] t_tab_idx;

    typedef struct packed {
        logic load;
        logic add;
        logic clr;
        logic shift;
    } t_mac_ctl;

    localparam t_cfg_idx CFG_MID_SLEW_GAIN  = 4'd0;
    localparam t_cfg_idx CFG_MID_SHAPE      = 4'd1;
    localparam t_cfg_idx CFG_MID_WET        = 4'd2;
    localparam t_cfg_idx CFG_SIDE_SLEW_GAIN = 4'd3;
    localparam t_cfg_idx CFG_SIDE_SHAPE     = 4'd4;
    localparam t_cfg_idx CFG_SIDE_WET       = 4'd5;
    localparam t_cfg_idx CFG_SEED_LEFT      = 4'd6;
    localparam t_cfg_idx CFG_SEED_RIGHT     = 4'd7;

    localparam logic [15:0] RST_SLEW_GAIN = 16'd2908;
    localparam logic [16:0] RST_SHAPE     = 17'd16384;
    localparam logic [16:0] RST_WET       = 17'd65536;
    localparam logic [31:0] RST_SEED_LEFT  = 32'd2463534242;
    localparam logic [31:0] RST_SEED_RIGHT = 32'd1013904223;

    localparam logic [16:0] UNITY16 = 17'd65536;
    localparam logic [16:0] SHAPE_LOW_MAX  = 17'd32761;
    localparam logic [16:0] SHAPE_HIGH_MIN = 17'd32775;

    localparam t_acc  Q28_ONE    = 66'sd268435456;
    localparam t_opnd Q28_ONE_OP = 33'sd268435456;
    localparam t_opnd K020_Q32   = 33'sd858993459;
    localparam t_opnd K086_Q32   = 33'sd3693671875;
    localparam t_opnd INV_2PI    = 33'sd683565276;
    localparam t_opnd SLOPE_Q16  = 33'sd162005;
    localparam logic signed [48:0] WALK_LIM = 49'sd140733193388032;
    localparam longint PI_HALF_Q30 = 64'sd1686629713;

    function automatic t_acc shr_tz(input t_acc v, input int unsigned sh);
        t_acc m;
        m = -v;
        if (v < 0) begin
            return -(m >>> sh);
        end
        return v >>> sh;
    endfunction

    function automatic longint taylor_q30(input longint x);
        longint x2;
        longint term;
        longint sum;
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        term = ((term * x2) >>> 30) / 64'sd6;
        sum = sum - term;
        term = ((term * x2) >>> 30) / 64'sd20;
        sum = sum + term;
        term = ((term * x2) >>> 30) / 64'sd42;
        sum = sum - term;
        term = ((term * x2) >>> 30) / 64'sd72;
        sum = sum + term;
        term = ((term * x2) >>> 30) / 64'sd110;
        sum = sum - term;
        term = ((term * x2) >>> 30) / 64'sd156;
        sum = sum + term;
        return sum;
    endfunction

    function automatic t_tab build_sin();
        t_tab   t;
        longint s;
        for (int i = 0; i <= TAB_N; i++) begin
            s = taylor_q30((PI_HALF_Q30 * longint'(i)) / TAB_N);
            if (s < 0) begin
                s = 0;
            end
            s = (s + 2) >>> 2;
            if (s > 268435456) begin
                s = 268435456;
            end
            t[i] = t_tab_word'(s);
        end
        return t;
    endfunction

    function automatic t_tab build_asin();
        t_tab   t;
        longint lo;
        longint hi;
        longint m;
        longint y;
        for (int i = 0; i <= TAB_N; i++) begin
            y = longint'(i) <<< (30 - TRIG_TABLE_BITS);
            lo = 0;
            hi = PI_HALF_Q30;
            for (int it = 0; it < 34; it++) begin
                if (lo < hi) begin
                    m = (lo + hi + 1) >>> 1;
                    if (taylor_q30(m) <= y) begin
                        lo = m;
                    end else begin
                        hi = m - 1;
                    end
                end
            end
            t[i] = t_tab_word'((lo + 2) >>> 2);
        end
        return t;
    endfunction

    localparam t_tab SIN_TAB  = build_sin();
    localparam t_tab ASIN_TAB = build_asin();

endpackage

// ===== sv/mst_if.sv =====
interface mst_in_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] left_sample;
    logic signed [W-1:0] right_sample;
    modport source(output valid, left_sample, right_sample, input ready);
    modport sink(input valid, left_sample, right_sample, output ready);
endinterface

interface mst_out_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] left_out;
    logic signed [W-1:0] right_out;
    modport source(output valid, left_out, right_out, input ready);
    modport sink(input valid, left_out, right_out, output ready);
endinterface

interface mst_cfg_if;
    logic                valid;
    logic                ready;
    mst_pkg::t_cfg_idx   index;
    logic [31:0]         data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/midside_slew_noise_texturizer.sv =====
// Each path shapes with sin below the bypass band of the shape setting, with asin above it,
// and not at all inside the band; the mid path runs first, then the side path.
// One multiplier serves every product of both paths; each product is loaded, then added.
// A new frame is not taken before the last one is through: input is not ready while a frame
// is in work, and a waiting output beat holds the next frame back.
// Reset (synchronous, active low) loads default settings and seeds, clears state.
module midside_slew_noise_texturizer #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mst_in_if.sink       i_in,
    mst_out_if.source    o_out,
    mst_cfg_if.sink      i_cfg
);
    import mst_pkg::*;

    localparam int ISH = 29 - SAMPLE_BITS;
    localparam int unsigned ISH_L = (ISH >= 0) ? ISH : 0;
    localparam int unsigned ISH_R = (ISH < 0) ? -ISH : 0;
    localparam int OSH = 30 - SAMPLE_BITS;
    localparam int unsigned OSH_R = (OSH >= 0) ? OSH : 0;
    localparam int unsigned OSH_L = (OSH < 0) ? -OSH : 0;
    localparam t_acc OUT_HI = (t_acc'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam t_acc OUT_LO = -OUT_HI - 1;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_PREP     = 5'd1;
    localparam logic [4:0] ST_SHP_PH   = 5'd2;
    localparam logic [4:0] ST_TRIG_RD  = 5'd3;
    localparam logic [4:0] ST_TRIG_MUL = 5'd4;
    localparam logic [4:0] ST_MIX_A    = 5'd5;
    localparam logic [4:0] ST_MIX_B    = 5'd6;
    localparam logic [4:0] ST_U        = 5'd7;
    localparam logic [4:0] ST_V        = 5'd8;
    localparam logic [4:0] ST_W_LO     = 5'd9;
    localparam logic [4:0] ST_W_HI     = 5'd10;
    localparam logic [4:0] ST_SLEW     = 5'd11;
    localparam logic [4:0] ST_PREV     = 5'd12;
    localparam logic [4:0] ST_T        = 5'd13;
    localparam logic [4:0] ST_II       = 5'd14;
    localparam logic [4:0] ST_LP_A     = 5'd15;
    localparam logic [4:0] ST_LP_B     = 5'd16;
    localparam logic [4:0] ST_SM_A     = 5'd17;
    localparam logic [4:0] ST_SM_B     = 5'd18;
    localparam logic [4:0] ST_OUT_A    = 5'd19;
    localparam logic [4:0] ST_OUT_B    = 5'd20;
    localparam logic [4:0] ST_DONE     = 5'd21;

    function automatic t_acc to_q28(input logic signed [SAMPLE_BITS-1:0] v);
        t_acc e;
        e = t_acc'(v);
        if (ISH >= 0) begin
            return e <<< ISH_L;
        end
        return shr_tz(e, ISH_R);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] to_out(input t_acc v);
        t_acc s;
        if (OSH >= 0) begin
            s = shr_tz(v, OSH_R);
        end else begin
            s = v <<< OSH_L;
        end
        if (s > OUT_HI) begin
            s = OUT_HI;
        end
        if (s < OUT_LO) begin
            s = OUT_LO;
        end
        return s[SAMPLE_BITS-1:0];
    endfunction

    logic [4:0] r_state;
    logic [4:0] r_ret;
    logic       r_phase;
    logic       r_path;
    logic       r_tsel;
    logic       r_mode_asin;

    logic [15:0] r_gain [2];
    logic [16:0] r_shape [2];
    logic [16:0] r_wet [2];
    logic [31:0] r_rng [2];

    logic               r_pos [2];
    logic               r_up [2];
    logic signed [47:0] r_walk [2];
    logic signed [31:0] r_prev [2];
    logic signed [31:0] r_lp [2];
    logic signed [31:0] r_sm [2];

    logic signed [30:0] r_xm;
    logic signed [30:0] r_xs;
    logic signed [30:0] r_s;
    logic [31:0]        r_ph;
    logic [FS_SIN-1:0]  r_frac;
    logic               r_neg;
    logic signed [30:0] r_trig;
    logic [31:0]        r_u;
    logic [29:0]        r_v;
    logic [28:0]        r_slew;
    logic [29:0]        r_t;
    logic [28:0]        r_ii;
    logic signed [30:0] r_m;
    logic signed [30:0] r_sd;

    logic                          r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_lo_out;
    logic signed [SAMPLE_BITS-1:0] r_ro_out;

    t_mac_ctl  ctl;
    t_opnd     opa;
    t_opnd     opb;
    t_acc      sum;
    t_tab_word rom_lo;
    t_tab_word rom_hi;
    t_tab_idx  rom_idx;
    logic [FS_SIN-1:0] n_frac;
    logic      n_neg;
    logic      is_mul;

    logic signed [30:0] x_sel;
    logic [16:0]        d_val;
    logic [16:0]        w_val;
    t_opnd              d2;
    t_opnd              c1;
    t_opnd              c2;
    t_opnd              s_op;
    t_opnd              mag;
    t_opnd              dif;
    t_opnd              slew_abs;
    logic               up_eff;
    logic signed [48:0] wk;
    logic signed [48:0] wsum;
    logic signed [47:0] n_walk;
    logic signed [30:0] clamp_x;
    logic [30:0]        pos;
    logic [30:0]        amag;
    t_acc               trig_v;
    t_acc               t_sh;
    logic               out_write;

    mst_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_a   (opa),
        .i_b   (opb),
        .o_sum (sum)
    );

    mst_trig_rom u_rom (
        .i_clk  (i_clk),
        .i_rd   (r_state == ST_TRIG_RD),
        .i_asin (r_tsel),
        .i_idx  (rom_idx),
        .o_lo   (rom_lo),
        .o_hi   (rom_hi)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ovalid;
    assign o_out.left_out = r_lo_out;
    assign o_out.right_out = r_ro_out;

    always_comb begin
        x_sel = r_path ? r_xs : r_xm;
        d_val = (r_shape[r_path] > UNITY16) ? UNITY16 : r_shape[r_path];
        w_val = (r_wet[r_path] > UNITY16) ? UNITY16 : r_wet[r_path];
        d2 = t_opnd'({d_val, 1'b0});
        if (r_mode_asin) begin
            c1 = t_opnd'(131072) - d2;
            c2 = d2 - t_opnd'(UNITY16);
        end else begin
            c1 = d2;
            c2 = t_opnd'(UNITY16) - d2;
        end
        s_op = t_opnd'(r_s);
        mag = (s_op < 0) ? -s_op : s_op;
        dif = s_op - t_opnd'(r_prev[r_path]);
        slew_abs = (dif < 0) ? -dif : dif;

        up_eff = (x_sel < 0 && r_pos[r_path]) ? (r_walk[r_path] < 0) : r_up[r_path];
        wk = 49'(r_walk[r_path]);
        if (up_eff) begin
            wsum = wk + 49'({17'b0, r_rng[r_path]});
            if (wsum > WALK_LIM) begin
                wsum = WALK_LIM;
            end
        end else begin
            wsum = wk - 49'({17'b0, r_rng[r_path]});
            if (wsum < -WALK_LIM) begin
                wsum = -WALK_LIM;
            end
        end
        n_walk = wsum[47:0];

        if (x_sel > 31'sd268435456) begin
            clamp_x = 31'sd268435456;
        end else if (x_sel < -31'sd268435456) begin
            clamp_x = -31'sd268435456;
        end else begin
            clamp_x = x_sel;
        end

        pos = r_ph[30] ? (31'h40000000 - {1'b0, r_ph[29:0]}) : {1'b0, r_ph[29:0]};
        amag = (r_s < 0) ? 31'(-r_s) : 31'(r_s);
        if (amag > 31'd268435456) begin
            amag = 31'd268435456;
        end
        if (r_tsel) begin
            rom_idx = amag[28:FS_ASIN];
            n_frac = FS_SIN'(amag[FS_ASIN-1:0]);
            n_neg = r_s < 0;
        end else begin
            rom_idx = pos[30:FS_SIN];
            n_frac = pos[FS_SIN-1:0];
            n_neg = r_ph[31];
        end

        t_sh = shr_tz(sum, r_tsel ? FS_ASIN : FS_SIN);
        trig_v = t_acc'(rom_lo) + t_sh;
        if (r_neg) begin
            trig_v = -trig_v;
        end
    end

    always_comb begin
        opa = '0;
        opb = '0;
        is_mul = 1'b1;
        ctl.clr = 1'b1;
        ctl.shift = 1'b0;
        unique case (r_state)
            ST_SHP_PH: begin
                opa = s_op;
                opb = INV_2PI;
            end
            ST_TRIG_MUL: begin
                opa = t_opnd'(rom_hi) - t_opnd'(rom_lo);
                opb = t_opnd'(r_frac);
            end
            ST_MIX_A: begin
                opa = s_op;
                opb = c1;
            end
            ST_MIX_B: begin
                opa = t_opnd'(r_trig);
                opb = c2;
                ctl.clr = 1'b0;
            end
            ST_U: begin
                opa = mag;
                opb = K020_Q32 - t_opnd'({d_val, 13'b0});
            end
            ST_V: begin
                opa = t_opnd'(r_u);
                opb = INV_2PI;
            end
            ST_W_LO: begin
                opa = t_opnd'(r_walk[r_path][23:0]);
                opb = t_opnd'(r_v);
            end
            ST_W_HI: begin
                opa = t_opnd'(signed'(r_walk[r_path][47:24]));
                opb = t_opnd'(r_v);
                ctl.clr = 1'b0;
                ctl.shift = 1'b1;
            end
            ST_SLEW: begin
                opa = slew_abs;
                opb = t_opnd'(r_gain[r_path]);
            end
            ST_PREV: begin
                opa = s_op;
                opb = K086_Q32 - t_opnd'({d_val, 13'b0});
            end
            ST_T: begin
                opa = t_opnd'(r_slew);
                opb = SLOPE_Q16;
            end
            ST_II: begin
                opa = t_opnd'(r_t);
                opb = t_opnd'(r_t);
            end
            ST_LP_A: begin
                opa = t_opnd'(r_lp[r_path]);
                opb = Q28_ONE_OP - t_opnd'(r_ii);
            end
            ST_LP_B: begin
                opa = t_opnd'(r_trig);
                opb = t_opnd'(r_ii);
                ctl.clr = 1'b0;
            end
            ST_SM_A: begin
                opa = t_opnd'(r_lp[r_path]);
                opb = t_opnd'(r_slew);
            end
            ST_SM_B: begin
                opa = t_opnd'(r_sm[r_path]);
                opb = Q28_ONE_OP - t_opnd'(r_slew);
                ctl.clr = 1'b0;
            end
            ST_OUT_A: begin
                opa = t_opnd'(r_sm[r_path]);
                opb = t_opnd'(w_val);
            end
            ST_OUT_B: begin
                opa = t_opnd'(x_sel);
                opb = t_opnd'(UNITY16) - t_opnd'(w_val);
                ctl.clr = 1'b0;
            end
            default: begin
                is_mul = 1'b0;
            end
        endcase
        ctl.load = is_mul & ~r_phase;
        ctl.add = is_mul & r_phase;
    end

    assign out_write = (r_state == ST_DONE) && (!r_ovalid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret <= ST_IDLE;
            r_phase <= 1'b0;
            r_path <= 1'b0;
            r_tsel <= 1'b0;
            r_mode_asin <= 1'b0;
            r_ovalid <= 1'b0;
            r_gain[0] <= RST_SLEW_GAIN;
            r_gain[1] <= RST_SLEW_GAIN;
            r_shape[0] <= RST_SHAPE;
            r_shape[1] <= RST_SHAPE;
            r_wet[0] <= RST_WET;
            r_wet[1] <= RST_WET;
            r_rng[0] <= RST_SEED_LEFT;
            r_rng[1] <= RST_SEED_RIGHT;
            for (int i = 0; i < 2; i++) begin
                r_pos[i] <= 1'b0;
                r_up[i] <= 1'b1;
                r_walk[i] <= '0;
                r_prev[i] <= '0;
                r_lp[i] <= '0;
                r_sm[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_MID_SLEW_GAIN:  r_gain[0] <= i_cfg.data[15:0];
                    CFG_MID_SHAPE:      r_shape[0] <= i_cfg.data[16:0];
                    CFG_MID_WET:        r_wet[0] <= i_cfg.data[16:0];
                    CFG_SIDE_SLEW_GAIN: r_gain[1] <= i_cfg.data[15:0];
                    CFG_SIDE_SHAPE:     r_shape[1] <= i_cfg.data[16:0];
                    CFG_SIDE_WET:       r_wet[1] <= i_cfg.data[16:0];
                    CFG_SEED_LEFT:      r_rng[0] <= i_cfg.data;
                    CFG_SEED_RIGHT:     r_rng[1] <= i_cfg.data;
                    default: begin
                    end
                endcase
            end

            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            if (is_mul) begin
                r_phase <= ~r_phase;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_xm <= 31'(to_q28(i_in.left_sample) + to_q28(i_in.right_sample));
                        r_xs <= 31'(to_q28(i_in.left_sample) - to_q28(i_in.right_sample));
                        r_path <= 1'b0;
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_pos[r_path] <= (x_sel >= 0);
                    r_up[r_path] <= ~up_eff;
                    r_walk[r_path] <= n_walk;
                    r_s <= clamp_x;
                    if (d_val <= SHAPE_LOW_MAX) begin
                        r_mode_asin <= 1'b0;
                        r_state <= ST_SHP_PH;
                    end else if (d_val >= SHAPE_HIGH_MIN) begin
                        r_mode_asin <= 1'b1;
                        r_tsel <= 1'b1;
                        r_ret <= ST_MIX_A;
                        r_state <= ST_TRIG_RD;
                    end else begin
                        r_state <= ST_U;
                    end
                end
                ST_SHP_PH: begin
                    if (r_phase) begin
                        r_ph <= sum[59:28];
                        r_tsel <= 1'b0;
                        r_ret <= ST_MIX_A;
                        r_state <= ST_TRIG_RD;
                    end
                end
                ST_TRIG_RD: begin
                    r_frac <= n_frac;
                    r_neg <= n_neg;
                    r_state <= ST_TRIG_MUL;
                end
                ST_TRIG_MUL: begin
                    if (r_phase) begin
                        r_trig <= trig_v[30:0];
                        r_state <= r_ret;
                    end
                end
                ST_MIX_A: begin
                    if (r_phase) begin
                        r_state <= ST_MIX_B;
                    end
                end
                ST_MIX_B: begin
                    if (r_phase) begin
                        r_s <= 31'(shr_tz(sum, 16));
                        r_state <= ST_U;
                    end
                end
                ST_U: begin
                    if (r_phase) begin
                        r_u <= sum[59:28];
                        r_state <= ST_V;
                    end
                end
                ST_V: begin
                    if (r_phase) begin
                        r_v <= sum[61:32];
                        r_state <= ST_W_LO;
                    end
                end
                ST_W_LO: begin
                    if (r_phase) begin
                        r_state <= ST_W_HI;
                    end
                end
                ST_W_HI: begin
                    if (r_phase) begin
                        r_ph <= sum[63:32];
                        r_tsel <= 1'b0;
                        r_ret <= ST_SLEW;
                        r_state <= ST_TRIG_RD;
                    end
                end
                ST_SLEW: begin
                    if (r_phase) begin
                        r_slew <= ((sum >>> 12) > Q28_ONE) ? 29'd268435456 : sum[40:12];
                        r_state <= ST_PREV;
                    end
                end
                ST_PREV: begin
                    if (r_phase) begin
                        r_prev[r_path] <= 32'(shr_tz(sum, 32));
                        r_state <= ST_T;
                    end
                end
                ST_T: begin
                    if (r_phase) begin
                        r_t <= sum[45:16];
                        r_state <= ST_II;
                    end
                end
                ST_II: begin
                    if (r_phase) begin
                        r_ii <= ((sum >>> 28) > Q28_ONE) ? 29'd268435456 : sum[56:28];
                        r_state <= ST_LP_A;
                    end
                end
                ST_LP_A: begin
                    if (r_phase) begin
                        r_state <= ST_LP_B;
                    end
                end
                ST_LP_B: begin
                    if (r_phase) begin
                        r_lp[r_path] <= 32'(shr_tz(sum, 28));
                        r_state <= ST_SM_A;
                    end
                end
                ST_SM_A: begin
                    if (r_phase) begin
                        r_state <= ST_SM_B;
                    end
                end
                ST_SM_B: begin
                    if (r_phase) begin
                        r_sm[r_path] <= 32'(shr_tz(sum, 28));
                        r_state <= ST_OUT_A;
                    end
                end
                ST_OUT_A: begin
                    if (r_phase) begin
                        r_state <= ST_OUT_B;
                    end
                end
                ST_OUT_B: begin
                    if (r_phase) begin
                        if (r_path) begin
                            r_sd <= 31'(shr_tz(sum, 16));
                            r_state <= ST_DONE;
                        end else begin
                            r_m <= 31'(shr_tz(sum, 16));
                            r_path <= 1'b1;
                            r_state <= ST_PREP;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_write) begin
                        r_lo_out <= to_out(t_acc'(r_m) + t_acc'(r_sd));
                        r_ro_out <= to_out(t_acc'(r_m) - t_acc'(r_sd));
                        r_ovalid <= 1'b1;
                        for (int i = 0; i < 2; i++) begin
                            r_rng[i] <= r_rng[i] ^ (r_rng[i] << 13)
                                ^ ((r_rng[i] ^ (r_rng[i] << 13)) >> 17)
                                ^ (((r_rng[i] ^ (r_rng[i] << 13))
                                    ^ ((r_rng[i] ^ (r_rng[i] << 13)) >> 17)) << 5);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== sv/mst_mac.sv =====
module mst_mac (
    input  logic              i_clk,
    input  mst_pkg::t_mac_ctl i_ctl,
    input  mst_pkg::t_opnd    i_a,
    input  mst_pkg::t_opnd    i_b,
    output mst_pkg::t_acc     o_sum
);
    import mst_pkg::*;

    t_acc r_prod;
    t_acc r_acc;
    t_acc prod;
    t_acc base;
    t_acc addend;

    assign prod = i_a * i_b;

    always_comb begin
        base = i_ctl.clr ? '0 : r_acc;
        addend = i_ctl.shift ? (r_prod <<< MAC_SHIFT) : r_prod;
        o_sum = base + addend;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= prod;
        end
        if (i_ctl.add) begin
            r_acc <= o_sum;
        end
    end
endmodule

// ===== sv/mst_trig_rom.sv =====
module mst_trig_rom (
    input  logic               i_clk,
    input  logic               i_rd,
    input  logic               i_asin,
    input  mst_pkg::t_tab_idx  i_idx,
    output mst_pkg::t_tab_word o_lo,
    output mst_pkg::t_tab_word o_hi
);
    import mst_pkg::*;

    t_tab_idx  idx_nx;
    t_tab_word r_lo;
    t_tab_word r_hi;

    assign idx_nx = (i_idx == t_tab_idx'(TAB_N)) ? i_idx : i_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_lo <= i_asin ? ASIN_TAB[i_idx] : SIN_TAB[i_idx];
            r_hi <= i_asin ? ASIN_TAB[idx_nx] : SIN_TAB[idx_nx];
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;
endmodule
